FILE: design/assert_macros.svh
// assertion macros for the limiter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define PTBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define PTBL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ptbl_pkg.sv
// shared types and constants for the per-address token bucket limiter
`timescale 1ns / 1ps

package ptbl_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  // outcome codes
  localparam logic [2:0] OUT_NEW    = 3'd0;
  localparam logic [2:0] OUT_ADMIT  = 3'd1;
  localparam logic [2:0] OUT_REFUSE = 3'd2;
  localparam logic [2:0] OUT_FULL   = 3'd3;
  localparam logic [2:0] OUT_ZERO   = 3'd4;

  // register indexes
  localparam logic [7:0] REG_TOKENS   = 8'd0;
  localparam logic [7:0] REG_INTERVAL = 8'd1;

  // shared unit operations
  localparam logic ALU_MUL = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic [31:0] refill_time;
    logic [7:0]  tokens;
    logic [31:0] address;
  } slot_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_t             data;
  } slot_wr_t;

endpackage

FILE: design/per_address_token_bucket_limiter.sv
// top level: per-address token bucket admission limiter with probing sequencer
//
//  channel | direction | handshake               | payload
//  in_     | slave     | in_tvalid / in_tready   | in_tdata: client_address, current_time
//  out_    | master    | out_tvalid / out_tready | out_tdata: admitted, outcome
//  cfg_    | slave     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// after reset a clearing pass empties every slot of the table, with in_tready low
// address zero goes straight to the result; any other address is hashed, then each probe
// reads one table slot, and a tracked client adds an elapsed-time step and an update step
// a result waits in the output register; a stalled output holds the sequencer in its
// last step, and the next transaction is taken as soon as the result is loaded
`timescale 1ns / 1ps

module per_address_token_bucket_limiter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] client_address, [63:32] current_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] admitted, [3:1] outcome, [7:4] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ptbl_pkg::*;
  `include "assert_macros.svh"

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_HASH  = 4'd2;
  localparam logic [3:0] ST_LOAD  = 4'd3;
  localparam logic [3:0] ST_READ  = 4'd4;
  localparam logic [3:0] ST_EVAL  = 4'd5;
  localparam logic [3:0] ST_ELAP  = 4'd6;
  localparam logic [3:0] ST_UPD   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] probe_r, probe_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [7:0]        tok_r, tok_nxt;
  logic [31:0]       rtime_r, rtime_nxt;
  logic              adm_r, adm_nxt;
  logic [2:0]        outc_r, outc_nxt;
  logic [7:0]        tpw_r, tpw_nxt;
  logic [15:0]       ivl_r, ivl_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;

  logic        alu_op;
  logic [31:0] alu_a, alu_b, alu_res;
  slot_wr_t    wr;
  slot_t       rd_data;
  logic        in_acc, out_load, refill;
  logic [7:0]  tok_eff, tok_init;

  ptbl_alu u_alu (
    .clk (clk),
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  ptbl_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  assign tok_init = (tpw_r == 8'd0) ? 8'd0 : tpw_r - 8'd1;
  // negative elapsed time never refills
  assign refill   = !alu_res[31] && (alu_res >= {16'd0, ivl_r});
  assign tok_eff  = refill ? tpw_r : tok_r;

  always_comb begin
    alu_op = ALU_MUL;
    alu_a  = addr_r;
    alu_b  = HASH_MULT;
    if (state_r == ST_ELAP) begin
      alu_op = ALU_SUB;
      alu_a  = now_r;
      alu_b  = rtime_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    idx_nxt   = idx_r;
    probe_nxt = probe_r;
    addr_nxt  = addr_r;
    now_nxt   = now_r;
    tok_nxt   = tok_r;
    rtime_nxt = rtime_r;
    adm_nxt   = adm_r;
    outc_nxt  = outc_r;
    wr        = '0;
    case (state_r)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          addr_nxt = in_tdata[31:0];
          now_nxt  = in_tdata[63:32];
          if (in_tdata[31:0] == 32'd0) begin
            adm_nxt   = 1'b1;
            outc_nxt  = OUT_ZERO;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        idx_nxt   = alu_res[SLOT_W-1:0];
        probe_nxt = '0;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (rd_data.address == 32'd0) begin
          wr.en                = 1'b1;
          wr.addr              = idx_r;
          wr.data.address      = addr_r;
          wr.data.tokens       = tok_init;
          wr.data.refill_time  = now_r;
          adm_nxt              = 1'b1;
          outc_nxt             = OUT_NEW;
          state_nxt            = ST_DONE;
        end else if (rd_data.address == addr_r) begin
          tok_nxt   = rd_data.tokens;
          rtime_nxt = rd_data.refill_time;
          state_nxt = ST_ELAP;
        end else if (probe_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          adm_nxt   = 1'b1;
          outc_nxt  = OUT_FULL;
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = (idx_r == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : idx_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_ELAP: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        wr.en               = 1'b1;
        wr.addr             = idx_r;
        wr.data.address     = addr_r;
        wr.data.refill_time = refill ? now_r : rtime_r;
        if (tok_eff == 8'd0) begin
          wr.data.tokens = 8'd0;
          adm_nxt        = 1'b0;
          outc_nxt       = OUT_REFUSE;
        end else begin
          wr.data.tokens = tok_eff - 8'd1;
          adm_nxt        = 1'b1;
          outc_nxt       = OUT_ADMIT;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'd0, outc_r, adm_r};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    tpw_nxt = tpw_r;
    ivl_nxt = ivl_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TOKENS:   tpw_nxt = cfg_data[7:0];
        REG_INTERVAL: ivl_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      tpw_r       <= 8'd10;
      ivl_r       <= 16'd60;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      tpw_r       <= tpw_nxt;
      ivl_r       <= ivl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    probe_r    <= probe_nxt;
    addr_r     <= addr_nxt;
    now_r      <= now_nxt;
    tok_r      <= tok_nxt;
    rtime_r    <= rtime_nxt;
    adm_r      <= adm_nxt;
    outc_r     <= outc_nxt;
    out_data_r <= out_data_nxt;
  end

  // a refused transaction is the only one that is not admitted
  `PTBL_ASSERT(a_refuse_flag, out_valid_r |-> (out_data_r[0] == (out_data_r[3:1] != OUT_REFUSE)), "admitted flag disagrees with outcome")
  // the table is written only while clearing, claiming or updating a slot
  `PTBL_ASSERT(a_write_state, wr.en |-> (state_r == ST_CLEAR || state_r == ST_EVAL || state_r == ST_UPD), "slot write outside a write step")
  // a nonzero address goes to the hash step, address zero straight to the result
  `PTBL_ASSERT(a_zero_path, (in_acc && in_tdata[31:0] == 32'd0) |=> (state_r == ST_DONE && outc_r == OUT_ZERO), "address zero not short cut")
  // nothing is accepted during the clearing pass after reset
  `PTBL_ASSERT_ALWAYS(a_clear_block, (!rst_n) |=> (!in_tready), "input ready during clearing pass")
endmodule

FILE: design/ptbl_mem.sv
// slot table memory, one write and one registered read per cycle
`timescale 1ns / 1ps

module ptbl_mem (
  input  logic                     clk,
  input  ptbl_pkg::slot_wr_t       wr,
  input  logic [ptbl_pkg::SLOT_W-1:0] rd_addr,
  output ptbl_pkg::slot_t          rd_data
);
  import ptbl_pkg::*;

  slot_t mem [TABLE_SLOTS];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/ptbl_alu.sv
// shared multiply / subtract unit with registered result
`timescale 1ns / 1ps

module ptbl_alu (
  input  logic        clk,
  input  logic        op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] res
);
  import ptbl_pkg::*;

  logic [63:0] prod;
  logic [31:0] res_nxt;
  logic [31:0] res_r;

  assign prod = a * b;

  always_comb begin
    case (op)
      ALU_MUL: res_nxt = prod[31:0];
      ALU_SUB: res_nxt = a - b;
      default: res_nxt = a - b;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

FILE: sim/tb_per_address_token_bucket_limiter.sv
// testbench for the per-address token bucket limiter: directed table, random traffic, full table
`timescale 1ns / 1ps

module tb_per_address_token_bucket_limiter;
  import ptbl_pkg::*;

  typedef struct packed {
    logic [2:0] outcome;
    logic       admitted;
  } verdict_t;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] now;
    logic        typed;
    logic        want_adm;
    logic [2:0]  want_out;
  } req_row_t;

  localparam int NUM_ROWS   = 22;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_REQS = 85;
  localparam int POOL_SIZE  = 12;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;

  // shadow of the client table and registers
  logic [31:0] slot_addr [TABLE_SLOTS];
  logic [7:0]  slot_tok  [TABLE_SLOTS];
  logic [31:0] slot_time [TABLE_SLOTS];
  logic [7:0]  tokens_cfg;
  logic [15:0] interval_cfg;
  int          slots_used;

  verdict_t    pending_verdicts [$];
  logic [31:0] client_pool [POOL_SIZE];
  req_row_t    directed [NUM_ROWS];

  int burst_left;
  int errors;
  int n_requests;
  int n_checked;
  int n_refused;
  int n_full;
  int n_zero;
  int n_settings;
  bit long_hold_done;

  per_address_token_bucket_limiter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  // admission decision for one request, updating the shadow table
  function automatic verdict_t judge_request(input logic [31:0] addr, input logic [31:0] now);
    logic [31:0] prod;
    logic [31:0] elapsed;
    int unsigned home;
    int unsigned idx;
    if (addr == 32'd0) return {OUT_ZERO, 1'b1};
    prod = addr * HASH_MULT;
    home = prod % TABLE_SLOTS;
    for (int p = 0; p < TABLE_SLOTS; p++) begin
      idx = (home + p) % TABLE_SLOTS;
      if (slot_addr[idx] == 32'd0) begin
        slot_addr[idx] = addr;
        slot_tok[idx]  = (tokens_cfg == 8'd0) ? 8'd0 : tokens_cfg - 8'd1;
        slot_time[idx] = now;
        slots_used++;
        return {OUT_NEW, 1'b1};
      end
      if (slot_addr[idx] == addr) begin
        elapsed = now - slot_time[idx];
        if (!elapsed[31] && elapsed >= {16'd0, interval_cfg}) begin
          slot_tok[idx]  = tokens_cfg;
          slot_time[idx] = now;
        end
        if (slot_tok[idx] == 8'd0) return {OUT_REFUSE, 1'b0};
        slot_tok[idx] = slot_tok[idx] - 8'd1;
        return {OUT_ADMIT, 1'b1};
      end
    end
    return {OUT_FULL, 1'b1};
  endfunction

  task automatic send_request(input logic [31:0] addr, input logic [31:0] now,
                              input logic typed, input verdict_t want);
    int gap;
    verdict_t v;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    v = judge_request(addr, now);
    if (typed) v = want;
    pending_verdicts.push_back(v);
    n_requests++;
    if (v.outcome == OUT_REFUSE) n_refused++;
    if (v.outcome == OUT_FULL) n_full++;
    if (v.outcome == OUT_ZERO) n_zero++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_TOKENS) tokens_cfg = val[7:0];
    else if (idx == REG_INTERVAL) interval_cfg = val;
  endtask

  // only called with no request in flight; an out-of-range index rides along and must be ignored
  task automatic set_config(input logic [15:0] tok, input logic [15:0] ivl);
    write_reg(REG_TOKENS, tok);
    write_reg(8'($urandom_range(2, 255)), 16'($urandom));
    write_reg(REG_INTERVAL, ivl);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[3:0];
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
      end else begin
        want = pending_verdicts.pop_front();
        n_checked++;
        if (got.admitted !== want.admitted) begin
          errors++;
          $display("%0t: admitted expected %0d actual %0d", $time, want.admitted, got.admitted);
        end
        if (got.outcome !== want.outcome) begin
          errors++;
          $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, got.outcome);
        end
      end
    end
  end

  // receiver: stall patterns plus one long hold-off to back the block up
  initial begin
    int mode;
    int len;
    int cyc;
    out_tready <= 1'b0;
    cyc = 0;
    forever begin
      if (!long_hold_done && n_requests >= 200) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold_done = 1;
      end
      mode = $urandom_range(0, 2);
      len  = $urandom_range(20, 200);
      repeat (len) begin
        case (mode)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= ($urandom_range(0, 99) < 60);
          end
          default: begin
            out_tready <= (cyc % 5 != 0);
          end
        endcase
        cyc++;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [15:0] tok_set [NUM_PHASES];
    logic [15:0] ivl_set [NUM_PHASES];
    logic [31:0] addr;
    logic [31:0] clk_now;
    logic [21:0] hi;
    logic [9:0]  low_bits;
    int          r;
    int          s;

    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_addr[i] = 32'd0;
      slot_tok[i]  = 8'd0;
      slot_time[i] = 32'd0;
    end
    tokens_cfg   = 8'd10;
    interval_cfg = 16'd60;
    slots_used   = 0;
    burst_left   = 0;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 64'd0;
    cfg_valid <= 1'b0;
    cfg_index <= 8'd0;
    cfg_data  <= 16'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: two tokens per window, 100 s interval; upper data bits must be dropped
    directed = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, OUT_ZERO},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, OUT_ZERO},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, OUT_NEW},
      '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1, OUT_ADMIT},
      '{32'hFFFF_FFFF, 32'h0000_0002, 1'b1, 1'b0, OUT_REFUSE},
      '{32'hFFFF_FFFF, 32'd99,        1'b1, 1'b0, OUT_REFUSE},
      '{32'hFFFF_FFFF, 32'd100,       1'b1, 1'b1, OUT_ADMIT},
      // elapsed negative: no refill
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, OUT_NEW},
      '{32'hFFFF_FFFF, 32'd50,        1'b0, 1'b0, OUT_NEW},
      // largest positive elapsed, then the first negative one
      '{32'hFFFF_FFFF, 32'h8000_0063, 1'b0, 1'b0, OUT_NEW},
      '{32'hFFFF_FFFF, 32'h0000_0063, 1'b0, 1'b0, OUT_NEW},
      '{32'hFFFF_FFFF, 32'h0000_0064, 1'b0, 1'b0, OUT_NEW},
      // shared home slot, second one probes on
      '{32'd1,         32'd5,         1'b1, 1'b1, OUT_NEW},
      '{32'd1025,      32'd5,         1'b1, 1'b1, OUT_NEW},
      '{32'd1025,      32'd6,         1'b0, 1'b0, OUT_NEW},
      '{32'd1,         32'd6,         1'b0, 1'b0, OUT_NEW},
      // home on the last slot, probe wraps to slot zero
      '{32'd175,       32'd7,         1'b1, 1'b1, OUT_NEW},
      '{32'd1199,      32'd7,         1'b1, 1'b1, OUT_NEW},
      '{32'd1199,      32'd8,         1'b0, 1'b0, OUT_NEW},
      '{32'd1024,      32'd8,         1'b0, 1'b0, OUT_NEW},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, OUT_NEW},
      '{32'h8000_0000, 32'h8000_0063, 1'b0, 1'b0, OUT_NEW}
    };
    set_config(16'hFF02, 16'd100);
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_request(directed[i].addr, directed[i].now, directed[i].typed,
                   {directed[i].want_out, directed[i].want_adm});
    end
    drain();

    tok_set = '{16'h00FF, 16'h0000, 16'h0001, 16'hAB03, 16'h0000, 16'h0005};
    ivl_set = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0008, 16'h0000, 16'h001E};
    tok_set[4] = 16'($urandom);
    ivl_set[4] = 16'($urandom);
    clk_now = $urandom;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_config(tok_set[ph], ivl_set[ph]);
      // half the pool collides with the other half on the home slot
      for (int k = 0; k < POOL_SIZE; k++) begin
        if (k < POOL_SIZE / 2) begin
          client_pool[k] = $urandom;
          if (client_pool[k] == 32'd0) client_pool[k] = 32'd1;
        end else begin
          hi = 22'($urandom);
          client_pool[k] = {hi, client_pool[k - POOL_SIZE / 2][9:0]};
        end
      end
      for (int n = 0; n < PHASE_REQS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 5) addr = 32'd0;
        else if (r < 15) addr = $urandom;
        else addr = client_pool[$urandom_range(0, POOL_SIZE - 1)];
        s = $urandom_range(0, 99);
        if (s < 60) clk_now = clk_now + $urandom_range(0, 2);
        else if (s < 85) clk_now = clk_now + $urandom_range(0, 2 * interval_cfg + 1);
        else if (s < 93) clk_now = clk_now - $urandom_range(0, interval_cfg);
        else clk_now = $urandom;
        send_request(addr, clk_now, 1'b0, '0);
      end
      drain();
    end

    // fill every slot; low address bits map one to one onto home slots
    set_config(16'd4, 16'd20);
    low_bits = 10'd0;
    while (slots_used < TABLE_SLOTS) begin
      hi = 22'($urandom);
      clk_now = clk_now + $urandom_range(0, 3);
      send_request({hi, low_bits}, clk_now, 1'b0, '0);
      low_bits++;
    end
    for (int n = 0; n < 12; n++) begin
      case (n % 3)
        0: addr = $urandom;
        1: addr = client_pool[$urandom_range(0, POOL_SIZE - 1)];
        default: addr = 32'd0;
      endcase
      send_request(addr, $urandom, 1'b0, '0);
    end
    drain();
    repeat (40) @(posedge clk);

    $display("run: %0d requests over %0d register settings, %0d results checked",
             n_requests, n_settings, n_checked);
    $display("run: %0d refused, %0d with table full, %0d zero address",
             n_refused, n_full, n_zero);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/ptbl_pkg.sv
design/ptbl_mem.sv
design/ptbl_alu.sv
design/per_address_token_bucket_limiter.sv
sim/tb_per_address_token_bucket_limiter.sv
